// ===== hdl/mtc_pkg.sv =====
// Shared types and constants for the 4x4 homogeneous matrix transform block.
// Holds the command encoding, the Q16.16 word type and the identity matrix.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    // Width of a product after dropping the 16 fraction bits.
    localparam int QPROD_W = PROD_W - 16;
    // Four such products summed without loss.
    localparam int SUM_W = QPROD_W + 2;

    typedef logic [WORD_W-1:0] word_t;
    // Column-major: element c*4+r is row r of column c.
    typedef logic [15:0][WORD_W-1:0] mat_t;

    typedef enum logic [2:0] {
        CMD_IDENTITY  = 3'd0,
        CMD_LOAD      = 3'd1,
        CMD_TRANSLATE = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_ROT_X     = 3'd4,
        CMD_ROT_Y     = 3'd5,
        CMD_ROT_Z     = 3'd6,
        CMD_TRANSFORM = 3'd7
    } cmd_t;

    localparam word_t Q_ONE    = 32'h0001_0000;
    localparam word_t Q_ZERO   = 32'h0000_0000;
    localparam word_t S32_MAX  = 32'h7FFF_FFFF;
    localparam word_t S32_MIN  = 32'h8000_0000;

    localparam mat_t MAT_IDENTITY = {Q_ONE, {4{Q_ZERO}}, Q_ONE, {4{Q_ZERO}},
                                     Q_ONE, {4{Q_ZERO}}, Q_ONE};

endpackage : mtc_pkg

`default_nettype wire

// ===== hdl/matrix_transform_compose.sv =====
// 4x4 homogeneous transform unit: input register, current matrix, four row
// units and the result register. Depends on mtc_pkg and mtc_row_unit.
`timescale 1ns / 1ps
//
// Usage:
// Each word on the slave side carries one command in s_axis_tuser and its
// operands in s_axis_tdata. Identity, load element, translate, scale and
// the three rotations update the current matrix and give no result word.
// Transform multiplies the current matrix by (x, y, z, w) and gives one
// result word on the master side. Rotations carry cosine and sine directly.
// An accepted word sits in the input register while sixteen parallel 32x32
// multipliers and the saturating adders compute; a transform's result then
// fills the result register on the master side. One word is taken every
// cycle while no transform waits on a stalled result; the matrix update
// loop (multiply, add, saturate, write back) has no register but the matrix,
// so a command sees all earlier updates. When the receiver stalls, the
// result register holds its word and a following transform waits in the
// input register, stalling the slave side; a command with no result still
// proceeds. Reset loads the identity matrix and empties both registers.
`default_nettype none

module matrix_transform_compose
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // elem_index[3:0], in_x[35:4], in_y[67:36], in_z[99:68], in_w[131:100], zero pad
    input  wire  [135:0] s_axis_tdata,
    // cmd[2:0]
    input  wire  [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] m_axis_tdata
);
    import mtc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    cmd_t        in_cmd_reg;
    logic [3:0]  in_idx_reg;
    word_t       in_x_reg;
    word_t       in_y_reg;
    word_t       in_z_reg;
    word_t       in_w_reg;

    mat_t        mat_reg;
    mat_t        mat_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    word_t [3:0] out_data_reg;

    logic        in_take;
    logic        adv;
    word_t       neg_sin;
    word_t       vec_w;

    word_t [3:0] op_a [4];
    word_t [3:0] op_b [4];
    word_t       sum4    [4];
    word_t       pair_lo [4];
    word_t       pair_hi [4];
    word_t [3:0] single  [4];

    // A transform moves on only when the result register is free or being drained.
    assign adv = in_valid_reg
               && ((in_cmd_reg != CMD_TRANSFORM) || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_idx_reg <= s_axis_tdata[3:0];
            in_x_reg   <= s_axis_tdata[35:4];
            in_y_reg   <= s_axis_tdata[67:36];
            in_z_reg   <= s_axis_tdata[99:68];
            in_w_reg   <= s_axis_tdata[131:100];
        end
    end

    // Negating the most negative sine saturates.
    assign neg_sin = (in_y_reg == S32_MIN) ? S32_MAX : (Q_ZERO - in_y_reg);
    assign vec_w   = (in_cmd_reg == CMD_TRANSFORM) ? in_w_reg : Q_ONE;

    // Operand steering. Rotations pair two columns i and j:
    // col i = mi*c + mj*b1, col j = mi*b2 + mj*c.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                op_a[r][k] = mat_reg[4*k+r];
            end
            op_b[r][0] = in_x_reg;
            op_b[r][1] = in_y_reg;
            op_b[r][2] = in_z_reg;
            op_b[r][3] = vec_w;
            case (in_cmd_reg)
                CMD_ROT_X:
                begin
                    op_a[r][0] = mat_reg[4+r];
                    op_a[r][1] = mat_reg[8+r];
                    op_a[r][2] = mat_reg[4+r];
                    op_a[r][3] = mat_reg[8+r];
                    op_b[r][0] = in_x_reg;
                    op_b[r][1] = in_y_reg;
                    op_b[r][2] = neg_sin;
                    op_b[r][3] = in_x_reg;
                end
                CMD_ROT_Y:
                begin
                    op_a[r][0] = mat_reg[r];
                    op_a[r][1] = mat_reg[8+r];
                    op_a[r][2] = mat_reg[r];
                    op_a[r][3] = mat_reg[8+r];
                    op_b[r][0] = in_x_reg;
                    op_b[r][1] = neg_sin;
                    op_b[r][2] = in_y_reg;
                    op_b[r][3] = in_x_reg;
                end
                CMD_ROT_Z:
                begin
                    op_a[r][0] = mat_reg[r];
                    op_a[r][1] = mat_reg[4+r];
                    op_a[r][2] = mat_reg[r];
                    op_a[r][3] = mat_reg[4+r];
                    op_b[r][0] = in_x_reg;
                    op_b[r][1] = in_y_reg;
                    op_b[r][2] = neg_sin;
                    op_b[r][3] = in_x_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    for (genvar gr = 0; gr < 4; gr++)
    begin : g_row
        mtc_row_unit u_row
        (
            .op_a    (op_a[gr]),
            .op_b    (op_b[gr]),
            .sum4    (sum4[gr]),
            .pair_lo (pair_lo[gr]),
            .pair_hi (pair_hi[gr]),
            .single  (single[gr])
        );
    end

    // The whole matrix is written at once from values computed on the old one.
    always_comb
    begin
        mat_next = mat_reg;
        if (adv)
        begin
            case (in_cmd_reg)
                CMD_IDENTITY:
                begin
                    mat_next = MAT_IDENTITY;
                end
                CMD_LOAD:
                begin
                    mat_next[in_idx_reg] = in_x_reg;
                end
                CMD_TRANSLATE:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        mat_next[12+r] = sum4[r];
                    end
                end
                CMD_SCALE:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mat_next[4*k+r] = single[r][k];
                        end
                    end
                end
                CMD_ROT_X:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        mat_next[4+r] = pair_lo[r];
                        mat_next[8+r] = pair_hi[r];
                    end
                end
                CMD_ROT_Y:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        mat_next[r]   = pair_lo[r];
                        mat_next[8+r] = pair_hi[r];
                    end
                end
                CMD_ROT_Z:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        mat_next[r]   = pair_lo[r];
                        mat_next[4+r] = pair_hi[r];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= MAT_IDENTITY;
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && (in_cmd_reg == CMD_TRANSFORM))
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (in_cmd_reg == CMD_TRANSFORM))
        begin
            for (int r = 0; r < 4; r++)
            begin
                out_data_reg[r] <= sum4[r];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_transform_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (in_cmd_reg == CMD_TRANSFORM) |=> out_valid_reg)
        else $error("transform did not fill the result register");

    a_transform_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (in_cmd_reg == CMD_TRANSFORM) && out_valid_reg && !m_axis_tready
        |-> !adv && !s_axis_tready)
        else $error("transform overran a stalled result");

    a_matrix_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(mat_reg))
        else $error("matrix changed without a command");

    a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (in_cmd_reg == CMD_LOAD) |=> mat_reg[$past(in_idx_reg)] == $past(in_x_reg))
        else $error("load element did not land");

    a_identity_diag: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (in_cmd_reg == CMD_IDENTITY) |=> (mat_reg == MAT_IDENTITY))
        else $error("identity command did not reset the matrix");

endmodule : matrix_transform_compose

`default_nettype wire

// ===== hdl/mtc_row_unit.sv =====
// One matrix row of the shared multiplier array: four Q16.16 products with
// floor rounding, plus the saturated sums and single terms built from them.
// Depends on mtc_pkg for word widths.
`timescale 1ns / 1ps
`default_nettype none

module mtc_row_unit
(
    input  wire mtc_pkg::word_t [3:0] op_a,
    input  wire mtc_pkg::word_t [3:0] op_b,
    output mtc_pkg::word_t            sum4,
    output mtc_pkg::word_t            pair_lo,
    output mtc_pkg::word_t            pair_hi,
    output mtc_pkg::word_t [3:0]      single
);
    import mtc_pkg::*;

    logic signed [PROD_W-1:0]  prod  [4];
    logic signed [QPROD_W-1:0] qprod [4];
    logic signed [SUM_W-1:0]   sum_all;
    logic signed [SUM_W-1:0]   sum_lo;
    logic signed [SUM_W-1:0]   sum_hi;

    // Clamp to the signed 32-bit range: in range when all upper bits match the sign.
    function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
        word_t r;
        if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1]))
        begin
            r = v[WORD_W-1:0];
        end
        else
        begin
            r = v[SUM_W-1] ? S32_MIN : S32_MAX;
        end
        return r;
    endfunction

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k]  = $signed(op_a[k]) * $signed(op_b[k]);
            // An arithmetic shift rounds toward minus infinity.
            qprod[k] = QPROD_W'(prod[k] >>> 16);
        end
        sum_lo  = SUM_W'(qprod[0]) + SUM_W'(qprod[1]);
        sum_hi  = SUM_W'(qprod[2]) + SUM_W'(qprod[3]);
        sum_all = sum_lo + sum_hi;
    end

    assign sum4    = sat_word(sum_all);
    assign pair_lo = sat_word(sum_lo);
    assign pair_hi = sat_word(sum_hi);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            single[k] = sat_word(SUM_W'(qprod[k]));
        end
    end

endmodule : mtc_row_unit

`default_nettype wire
